// ===== hw/rtl/cpiodf_pkg.sv =====
package cpiodf_pkg;

    // Header layout of the old binary format: thirteen little-endian words.
    localparam int unsigned HEADER_BYTES = 26;
    localparam logic [15:0] CPIO_MAGIC   = 16'o070707;
    localparam int unsigned TRAILER_LEN  = 10;

    // Word positions within the header that the block keeps or checks.
    localparam logic [3:0] WORD_MAGIC     = 4'd0;
    localparam logic [3:0] WORD_MODE      = 4'd3;
    localparam logic [3:0] WORD_NAME_SIZE = 4'd10;
    localparam logic [3:0] WORD_SIZE_HI   = 4'd11;
    localparam logic [3:0] WORD_SIZE_LO   = 4'd12;

    // Byte class codes as seen on the result channel.
    localparam logic [2:0] CLS_HEADER   = 3'd0;
    localparam logic [2:0] CLS_NAME     = 3'd1;
    localparam logic [2:0] CLS_NAME_PAD = 3'd2;
    localparam logic [2:0] CLS_DATA     = 3'd3;
    localparam logic [2:0] CLS_DATA_PAD = 3'd4;
    localparam logic [2:0] CLS_IGNORED  = 3'd5;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_NAME     = 6'b000010,
        PH_NAME_PAD = 6'b000100,
        PH_DATA     = 6'b001000,
        PH_DATA_PAD = 6'b010000,
        PH_IGNORE   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  data_out;
        logic [15:0] entry_mode;
        logic [15:0] name_length;
        logic [31:0] entry_size;
        logic [31:0] data_offset;
        logic        header_done;
        logic        last_of_name;
        logic        last_of_data;
        logic        archive_end;
        logic        bad_header;
    } t_result;

    // Characters of the name that marks the end of the archive.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/cpiodf_parse.sv =====
module cpiodf_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output cpiodf_pkg::t_result o_res
);
    import cpiodf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_mode, n_mode;
    logic [15:0] r_name_size, n_name_size;
    logic [15:0] r_size_hi, n_size_hi;
    logic [15:0] r_size_lo, n_size_lo;
    logic        r_trl_match, n_trl_match;
    logic        r_end_seen, n_end_seen;
    logic        r_error_seen, n_error_seen;

    logic [15:0] word;
    logic [31:0] size_full;
    logic [31:0] name_last_idx;
    logic [2:0]  cls;
    logic [31:0] offset;
    logic        hdr_done, last_name, last_data;

    assign word          = {i_byte, r_held};
    assign size_full     = {r_size_hi, r_size_lo};
    assign name_last_idx = {16'd0, r_name_size} - 32'd1;

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_held       = r_held;
        n_mode       = r_mode;
        n_name_size  = r_name_size;
        n_size_hi    = r_size_hi;
        n_size_lo    = r_size_lo;
        n_trl_match  = r_trl_match;
        n_end_seen   = r_end_seen;
        n_error_seen = r_error_seen;
        cls          = CLS_IGNORED;
        offset       = 32'd0;
        hdr_done     = 1'b0;
        last_name    = 1'b0;
        last_data    = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                cls = CLS_HEADER;
                if (!r_count[0]) begin
                    n_held = i_byte;
                end else begin
                    case (r_count[4:1])
                        WORD_MAGIC:     n_error_seen = (word != CPIO_MAGIC);
                        WORD_MODE:      n_mode       = word;
                        WORD_NAME_SIZE: n_name_size  = word;
                        WORD_SIZE_HI:   n_size_hi    = word;
                        WORD_SIZE_LO:   n_size_lo    = word;
                        default:        n_held       = r_held;
                    endcase
                end
                if (n_error_seen) begin
                    n_phase = PH_IGNORE;
                    n_count = 32'd0;
                end else if (r_count == 32'(HEADER_BYTES - 1)) begin
                    // The name size word is complete well before the last byte.
                    if (r_name_size == 16'd0) begin
                        n_error_seen = 1'b1;
                        n_phase      = PH_IGNORE;
                    end else begin
                        hdr_done    = 1'b1;
                        n_phase     = PH_NAME;
                        n_trl_match = 1'b1;
                    end
                    n_count = 32'd0;
                end else begin
                    n_count = r_count + 32'd1;
                end
            end
            PH_NAME: begin
                cls = CLS_NAME;
                if (r_count < 32'(TRAILER_LEN) && i_byte != trailer_char(r_count[3:0])) begin
                    n_trl_match = 1'b0;
                end
                if (r_count >= name_last_idx) begin
                    last_name = 1'b1;
                    n_count   = 32'd0;
                    if (n_trl_match && r_name_size == 16'(TRAILER_LEN + 1)) begin
                        n_end_seen = 1'b1;
                        n_phase    = PH_IGNORE;
                    end else if (r_name_size[0]) begin
                        n_phase = PH_NAME_PAD;
                    end else begin
                        n_phase = (size_full != 32'd0) ? PH_DATA : PH_HEADER;
                    end
                end else begin
                    n_count = r_count + 32'd1;
                end
            end
            PH_NAME_PAD: begin
                cls     = CLS_NAME_PAD;
                n_phase = (size_full != 32'd0) ? PH_DATA : PH_HEADER;
                n_count = 32'd0;
            end
            PH_DATA: begin
                cls    = CLS_DATA;
                offset = r_count;
                if (r_count >= size_full - 32'd1) begin
                    last_data = 1'b1;
                    n_phase   = size_full[0] ? PH_DATA_PAD : PH_HEADER;
                    n_count   = 32'd0;
                end else begin
                    n_count = r_count + 32'd1;
                end
            end
            PH_DATA_PAD: begin
                cls     = CLS_DATA_PAD;
                n_phase = PH_HEADER;
                n_count = 32'd0;
            end
            default: begin
                cls     = CLS_IGNORED;
                n_phase = PH_IGNORE;
                n_count = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_count      <= 32'd0;
            r_held       <= 8'd0;
            r_mode       <= 16'd0;
            r_name_size  <= 16'd0;
            r_size_hi    <= 16'd0;
            r_size_lo    <= 16'd0;
            r_trl_match  <= 1'b1;
            r_end_seen   <= 1'b0;
            r_error_seen <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_held       <= n_held;
            r_mode       <= n_mode;
            r_name_size  <= n_name_size;
            r_size_hi    <= n_size_hi;
            r_size_lo    <= n_size_lo;
            r_trl_match  <= n_trl_match;
            r_end_seen   <= n_end_seen;
            r_error_seen <= n_error_seen;
        end
    end

    always_comb begin
        o_res.byte_class   = cls;
        o_res.data_out     = i_byte;
        o_res.entry_mode   = n_mode;
        o_res.name_length  = n_name_size;
        o_res.entry_size   = {n_size_hi, n_size_lo};
        o_res.data_offset  = offset;
        o_res.header_done  = hdr_done;
        o_res.last_of_name = last_name;
        o_res.last_of_data = last_data;
        o_res.archive_end  = n_end_seen;
        o_res.bad_header   = n_error_seen;
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_seen |=> r_error_seen)
        else $error("error flag cleared without reset");

    a_stop_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_seen || r_end_seen) |-> r_phase == PH_IGNORE)
        else $error("parser left the ignore phase after an error or the trailer");

    a_header_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_count < 32'(HEADER_BYTES))
        else $error("header byte count ran past the header");

    a_name_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && hdr_done) |=> r_phase == PH_NAME)
        else $error("completed header not followed by the name");

endmodule

// ===== hw/rtl/cpiodf_out_stage.sv =====
module cpiodf_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cpiodf_pkg::t_result i_res,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output cpiodf_pkg::t_result o_res
);
    import cpiodf_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when it is empty or being drained.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/cpio_binary_archive_deframer_core.sv =====
// Old binary cpio deframer. Archive bytes enter one item at a time on the input
// channel, and for each one exactly one result item leaves: the byte itself, its
// class (header, name, name pad, file data, data pad, or ignored), the current
// entry's mode, name size and file size, the byte's offset within the file data,
// and flags that mark the end of a header, of a name and of the file data. The
// 26-byte header is read as thirteen little-endian words; a wrong magic or a zero
// name size raises a sticky bad_header flag, and the name TRAILER!!! raises a
// sticky archive_end flag. After either flag every byte is passed as ignored.
// The block takes one item in every cycle and delivers one result per cycle
// while the result side does not stall. Each item passes an input register and
// a result register, with the parse step between them. A stall on the result
// side holds the result register. The input register can still take an item
// while it is empty; once both registers are full, the input stall follows the
// result stall in the same cycle, so at most two items wait inside the block.
module cpio_binary_archive_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_byte_class,
    output logic [7:0]  o_data_out,
    output logic [15:0] o_entry_mode,
    output logic [15:0] o_name_length,
    output logic [31:0] o_entry_size,
    output logic [31:0] o_data_offset,
    output logic        o_header_done,
    output logic        o_last_of_name,
    output logic        o_last_of_data,
    output logic        o_archive_end,
    output logic        o_bad_header
);
    import cpiodf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_ready;
    logic       step;
    t_result    step_res;
    t_result    out_res;

    // An item moves from the input register into the parser and the result
    // register in the same cycle, whenever the result register can take it.
    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Parser state advances only on a step, so each item is seen once.
    cpiodf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    cpiodf_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (step),
        .i_res   (step_res),
        .i_stall (i_out_stall),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_byte_class   = out_res.byte_class;
    assign o_data_out     = out_res.data_out;
    assign o_entry_mode   = out_res.entry_mode;
    assign o_name_length  = out_res.name_length;
    assign o_entry_size   = out_res.entry_size;
    assign o_data_offset  = out_res.data_offset;
    assign o_header_done  = out_res.header_done;
    assign o_last_of_name = out_res.last_of_name;
    assign o_last_of_data = out_res.last_of_data;
    assign o_archive_end  = out_res.archive_end;
    assign o_bad_header   = out_res.bad_header;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import cpiodf_pkg::*;

    // The whole run, counted in clock cycles, is cut off here.
    localparam int CYCLE_LIMIT = 500000;
    // Once this many results have been taken, the receiver holds off for a long
    // stretch so that the block fills up and has to stall its input.
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 250;
    // Least number of archive bytes that are parsed normally before the archive is ended.
    localparam int ARCHIVE_BYTES = 1500;
    // Cycles to wait after the last result before the verdict.
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_byte_class;
    logic [7:0]  o_data_out;
    logic [15:0] o_entry_mode;
    logic [15:0] o_name_length;
    logic [31:0] o_entry_size;
    logic [31:0] o_data_offset;
    logic        o_header_done;
    logic        o_last_of_name;
    logic        o_last_of_data;
    logic        o_archive_end;
    logic        o_bad_header;

    cpio_binary_archive_deframer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_class   (o_byte_class),
        .o_data_out     (o_data_out),
        .o_entry_mode   (o_entry_mode),
        .o_name_length  (o_name_length),
        .o_entry_size   (o_entry_size),
        .o_data_offset  (o_data_offset),
        .o_header_done  (o_header_done),
        .o_last_of_name (o_last_of_name),
        .o_last_of_data (o_last_of_data),
        .o_archive_end  (o_archive_end),
        .o_bad_header   (o_bad_header)
    );

    always #6 i_clk = ~i_clk;

    // Archive bytes waiting to be sent, and the results that the accepted bytes
    // are expected to produce, oldest first.
    logic [7:0] archive_bytes[$];
    t_result    expected_results[$];

    int    mismatches = 0;
    int    results_seen = 0;
    int    cycle_count = 0;
    logic  hold_on = 1'b0;
    string trailer_name = "TRAILER!!!";

    // ------------------------------------------------------------------------
    // Parser model. It keeps its own copy of the block's state and, for every
    // byte the block accepts, works out the one result that byte must produce.
    // ------------------------------------------------------------------------
    t_phase      pm_phase = PH_HEADER;
    logic [31:0] pm_count = '0;
    logic [7:0]  pm_low_byte = '0;
    logic [15:0] pm_mode = '0;
    logic [15:0] pm_name_size = '0;
    logic [15:0] pm_size_hi = '0;
    logic [15:0] pm_size_lo = '0;
    logic        pm_trailer_match = 1'b1;
    logic        pm_end = 1'b0;
    logic        pm_error = 1'b0;

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result     r;
        logic [15:0] w;
        logic [31:0] fsz;
        r = '0;
        r.data_out = b;
        r.byte_class = CLS_IGNORED;
        fsz = {pm_size_hi, pm_size_lo};
        // Once either sticky flag is up, nothing else is parsed.
        if (pm_error || pm_end)
            pm_phase = PH_IGNORE;
        case (pm_phase)
            PH_HEADER: begin
                r.byte_class = CLS_HEADER;
                // Header words are little endian: the even byte is held until
                // the odd byte completes the word.
                if (!pm_count[0]) begin
                    pm_low_byte = b;
                end else begin
                    w = {b, pm_low_byte};
                    case (pm_count[4:1])
                        WORD_MAGIC:     if (w != CPIO_MAGIC) pm_error = 1'b1;
                        WORD_MODE:      pm_mode = w;
                        WORD_NAME_SIZE: pm_name_size = w;
                        WORD_SIZE_HI:   pm_size_hi = w;
                        WORD_SIZE_LO:   pm_size_lo = w;
                        default: ;
                    endcase
                end
                if (pm_error) begin
                    pm_phase = PH_IGNORE;
                    pm_count = '0;
                end else if (pm_count + 1 >= HEADER_BYTES) begin
                    // A header whose name size is zero is rejected on its last byte.
                    if (pm_name_size == 16'd0) begin
                        pm_error = 1'b1;
                        pm_phase = PH_IGNORE;
                    end else begin
                        r.header_done = 1'b1;
                        pm_phase = PH_NAME;
                        pm_trailer_match = 1'b1;
                    end
                    pm_count = '0;
                end else begin
                    pm_count = pm_count + 1;
                end
            end
            PH_NAME: begin
                r.byte_class = CLS_NAME;
                if (pm_count < TRAILER_LEN && b != trailer_name[pm_count])
                    pm_trailer_match = 1'b0;
                if (pm_count + 1 >= pm_name_size) begin
                    r.last_of_name = 1'b1;
                    // Only an eleven-byte name counts as the trailer, and its
                    // last byte is never compared.
                    if (pm_trailer_match && pm_name_size == TRAILER_LEN + 1) begin
                        pm_end = 1'b1;
                        pm_phase = PH_IGNORE;
                    end else if (pm_name_size[0]) begin
                        pm_phase = PH_NAME_PAD;
                    end else begin
                        pm_phase = (fsz != 0) ? PH_DATA : PH_HEADER;
                    end
                    pm_count = '0;
                end else begin
                    pm_count = pm_count + 1;
                end
            end
            PH_NAME_PAD: begin
                r.byte_class = CLS_NAME_PAD;
                pm_phase = (fsz != 0) ? PH_DATA : PH_HEADER;
                pm_count = '0;
            end
            PH_DATA: begin
                r.byte_class = CLS_DATA;
                r.data_offset = pm_count;
                if (pm_count >= fsz - 1) begin
                    r.last_of_data = 1'b1;
                    pm_phase = fsz[0] ? PH_DATA_PAD : PH_HEADER;
                    pm_count = '0;
                end else begin
                    pm_count = pm_count + 1;
                end
            end
            PH_DATA_PAD: begin
                r.byte_class = CLS_DATA_PAD;
                pm_phase = PH_HEADER;
                pm_count = '0;
            end
            default: begin
                pm_phase = PH_IGNORE;
                pm_count = '0;
            end
        endcase
        // The held words are shown after this byte has updated them.
        r.entry_mode = pm_mode;
        r.name_length = pm_name_size;
        r.entry_size = {pm_size_hi, pm_size_lo};
        r.archive_end = pm_end;
        r.bad_header = pm_error;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Archive construction.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte(input int fill);
        return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
    endfunction

    task automatic push_word(input logic [15:0] w);
        archive_bytes.insert(archive_bytes.size(), w[7:0]);
        archive_bytes.insert(archive_bytes.size(), w[15:8]);
    endtask

    // Thirteen words: magic, dev, ino, mode, uid, gid, nlink, rdev, two mtime
    // words, name size, and the file size as high and low word. The words that
    // the block does not keep get random contents.
    task automatic push_header(input logic [15:0] magic, input logic [15:0] mode,
                               input logic [15:0] nsize, input logic [31:0] fsize);
        push_word(magic);
        push_word(16'($urandom));
        push_word(16'($urandom));
        push_word(mode);
        for (int i = 0; i < 6; i++)
            push_word(16'($urandom));
        push_word(nsize);
        push_word(fsize[31:16]);
        push_word(fsize[15:0]);
    endtask

    // One complete entry: header, name, pads to even length and file data. The
    // name starts with the given prefix. Unless the entry is meant to end the
    // archive, a name that happens to spell the trailer is spoiled.
    task automatic push_entry(input logic [15:0] mode, input int nsize, input int fsize,
                              input string prefix, input int fill, input bit may_end);
        logic [7:0] name_bytes[$];
        bit         spells_trailer;
        push_header(CPIO_MAGIC, mode, 16'(nsize), 32'(fsize));
        for (int i = 0; i < nsize; i++)
            name_bytes.insert(name_bytes.size(),
                              i < prefix.len() ? prefix[i] : pick_byte(fill));
        spells_trailer = (nsize == TRAILER_LEN + 1);
        for (int i = 0; i < TRAILER_LEN && spells_trailer; i++)
            if (name_bytes[i] != trailer_name[i])
                spells_trailer = 1'b0;
        if (spells_trailer && !may_end)
            name_bytes[TRAILER_LEN - 1] = name_bytes[TRAILER_LEN - 1] ^ 8'h01;
        foreach (name_bytes[i])
            archive_bytes.insert(archive_bytes.size(), name_bytes[i]);
        if (nsize % 2 == 1)
            archive_bytes.insert(archive_bytes.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < fsize; i++)
            archive_bytes.insert(archive_bytes.size(), pick_byte(fill));
        if (fsize % 2 == 1)
            archive_bytes.insert(archive_bytes.size(), 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, reset and the end of the run.
    // ------------------------------------------------------------------------
    initial begin
        int nsize;
        int fsize;
        int kind;
        string prefix;

        // Directed entries first. The smallest name with no file data, which
        // needs a name pad and is followed straight by the next header.
        push_entry(16'h0000, 1, 0, "", 0, 1'b0);
        // All-ones bytes, an even name and a one-byte file that needs a data pad.
        push_entry(16'hFFFF, 2, 1, "", 255, 1'b0);
        // Names that come close to the trailer but must not end the archive:
        // the right size with one wrong character, the right text with one byte
        // too many, and the bare text without its terminating byte.
        push_entry(16'($urandom), 11, 2, "TRAILER!!?", -1, 1'b0);
        push_entry(16'($urandom), 12, 3, "TRAILER!!!", -1, 1'b0);
        push_entry(16'($urandom), 10, 0, "TRAILER!!!", -1, 1'b0);

        // Random entries with random contents. Most names and files are short;
        // now and then a long one, and some files are empty. Some names share
        // a beginning with the trailer.
        while (archive_bytes.size() < ARCHIVE_BYTES) begin
            nsize = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300)
                                                 : $urandom_range(1, 40);
            case ($urandom_range(0, 19))
                0, 1, 2, 3: fsize = 0;
                4:          fsize = $urandom_range(200, 700);
                default:    fsize = $urandom_range(1, 60);
            endcase
            prefix = ($urandom_range(0, 5) == 0)
                     ? trailer_name.substr(0, $urandom_range(0, TRAILER_LEN - 1)) : "";
            push_entry(16'($urandom), nsize, fsize, prefix, -1, 1'b0);
        end

        // The archive is closed by one of the three ways that stop parsing,
        // chosen at random: the trailer, a wrong magic or a zero name size.
        // Everything after it must come out as ignored.
        kind = $urandom_range(0, 2);
        case (kind)
            0: push_entry(16'($urandom), 11, $urandom_range(0, 5), trailer_name, -1, 1'b1);
            1: push_header(CPIO_MAGIC ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                           16'($urandom_range(1, 20)), 32'($urandom_range(0, 20)));
            default: push_header(CPIO_MAGIC, 16'($urandom), 16'd0,
                                 32'($urandom_range(0, 20)));
        endcase
        repeat ($urandom_range(20, 60))
            archive_bytes.insert(archive_bytes.size(), 8'($urandom_range(0, 255)));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every byte sent, then every result back, then a short drain so that
        // a stray extra result would still be caught.
        while (archive_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte sender. After each accepted item it waits a random number of cycles
    // before offering the next, except in quiet stretches and while the receiver
    // is holding off, when it offers back to back to fill the block up.
    // ------------------------------------------------------------------------
    int send_gap_left = 0;
    int send_quiet = 0;

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_data_byte <= 8'h00;
        end else if (i_in_valid && !o_in_stall) begin
            expected_results.insert(expected_results.size(), parse_byte(i_data_byte));
            if (send_quiet > 0)
                send_quiet--;
            else if ($urandom_range(0, 149) == 0)
                send_quiet = $urandom_range(20, 80);
            gap = (hold_on || send_quiet > 0) ? 0 : $urandom_range(0, 13);
            if (gap == 0 && archive_bytes.size() != 0) begin
                i_data_byte <= archive_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                send_gap_left = gap;
            end
        end else if (!i_in_valid) begin
            if (send_gap_left > 0) begin
                send_gap_left--;
            end else if (archive_bytes.size() != 0) begin
                i_in_valid <= 1'b1;
                i_data_byte <= archive_bytes.pop_front();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver and checker. Each accepted result is compared field by
    // field with the oldest expected one. After each result the receiver
    // stalls for a random number of cycles, except in quiet stretches, and once for a long stretch.
    // ------------------------------------------------------------------------
    int take_stall_left = 0;
    int take_quiet = 0;

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        int wait_cycles;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_on <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %0h",
                         $time, o_data_out);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("byte_class", 32'(want.byte_class), 32'(o_byte_class));
                check_field("data_out", 32'(want.data_out), 32'(o_data_out));
                check_field("entry_mode", 32'(want.entry_mode), 32'(o_entry_mode));
                check_field("name_length", 32'(want.name_length), 32'(o_name_length));
                check_field("entry_size", want.entry_size, o_entry_size);
                check_field("data_offset", want.data_offset, o_data_offset);
                check_field("header_done", 32'(want.header_done), 32'(o_header_done));
                check_field("last_of_name", 32'(want.last_of_name), 32'(o_last_of_name));
                check_field("last_of_data", 32'(want.last_of_data), 32'(o_last_of_data));
                check_field("archive_end", 32'(want.archive_end), 32'(o_archive_end));
                check_field("bad_header", 32'(want.bad_header), 32'(o_bad_header));
            end
            results_seen++;
            if (take_quiet > 0)
                take_quiet--;
            else if ($urandom_range(0, 149) == 0)
                take_quiet = $urandom_range(20, 80);
            if (results_seen == HOLD_AFTER) begin
                take_stall_left = HOLD_CYCLES;
                hold_on <= 1'b1;
                i_out_stall <= 1'b1;
            end else begin
                wait_cycles = (take_quiet > 0) ? 0 : $urandom_range(0, 13);
                take_stall_left = wait_cycles;
                i_out_stall <= (wait_cycles != 0);
            end
        end else if (take_stall_left > 0) begin
            take_stall_left--;
            if (take_stall_left == 0) begin
                i_out_stall <= 1'b0;
                hold_on <= 1'b0;
            end
        end
    end

    // A run that hangs is ended here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule
